>>> hw/rtl/ppmb_pkg.sv
`default_nettype none
package ppmb_pkg;

	localparam int unsigned MaxImageWidth  = 1920;
	localparam int unsigned MaxImageHeight = 1080;
	localparam int unsigned MinFileLength  = 20;
	localparam int unsigned FullScale      = 255;

	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_6     = 8'h36;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// status codes
	localparam logic [2:0] STS_OK      = 3'd0;
	localparam logic [2:0] STS_SHORT   = 3'd1;
	localparam logic [2:0] STS_MAGIC   = 3'd2;
	localparam logic [2:0] STS_BADNUM  = 3'd3;
	localparam logic [2:0] STS_TOOBIG  = 3'd4;

	// config register indexes
	localparam logic [2:0] REG_ENABLE = 3'd0;
	localparam logic [2:0] REG_SCR_W  = 3'd1;
	localparam logic [2:0] REG_SCR_H  = 3'd2;
	localparam logic [2:0] REG_PITCH  = 3'd3;
	localparam logic [2:0] REG_BASE   = 3'd4;
	localparam logic [2:0] REG_TOP    = 3'd5;
	localparam logic [2:0] REG_LENGTH = 3'd6;

	typedef enum logic [7:0] {
		PH_MAGIC  = 8'b00000001,
		PH_FORMAT = 8'b00000010,
		PH_WIDTH  = 8'b00000100,
		PH_HEIGHT = 8'b00001000,
		PH_MAXVAL = 8'b00010000,
		PH_P6     = 8'b00100000,
		PH_P3     = 8'b01000000,
		PH_DONE   = 8'b10000000
	} phase_t;

	typedef struct packed {
		logic        enable;
		logic [12:0] scr_w;
		logic [12:0] scr_h;
		logic [16:0] pitch;
		logic [31:0] base;
		logic [11:0] top;
		logic [23:0] flen;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic div_start;
		logic num;
		logic pix;
		logic mul;
		logic sum;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic num_go;
		logic need_div;
		logic div_busy;
		logic pix_go;
		logic stat_go;
	} sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/ppmb_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module ppmb_div import ppmb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [23:0] dividend,
	input  wire logic [15:0] divisor,
	output logic             busy,
	output logic [23:0]      quotient
);
	logic [15:0] rem_q;
	logic [15:0] den_q;
	logic [23:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [16:0] trial;

	assign trial = {rem_q, quo_q[23]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'd24;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= 16'(trial - {1'b0, den_q});
				quo_q <= {quo_q[22:0], 1'b1};
			end else begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[22:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

>>> hw/rtl/ppmb_dp.sv
`default_nettype none
module ppmb_dp import ppmb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic [7:0]  in_byte,
	input  wire logic        in_first,
	output logic             out_kind,
	output logic [31:0]      out_addr,
	output logic [31:0]      out_word,
	output logic [2:0]       out_code,
	output logic             out_last
);
	typedef struct packed {
		logic com;
		logic start;
		logic done;
		logic err;
	} scan_t;

	function automatic logic is_space(input logic [7:0] ch);
		return ch == CH_SPACE || ch == CH_TAB || ch == CH_LF || ch == CH_CR;
	endfunction

	function automatic scan_t scan_f(input logic [7:0] ch, input logic com, input logic p3);
		scan_t r;
		r = '0;
		r.com = com;
		if (com) begin
			if (ch == CH_LF) r.com = 1'b0;
		end else if (ch == CH_HASH) begin
			r.com = 1'b1;
		end else if (is_space(ch)) begin
			r.start = 1'b0;
		end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
			r.start = 1'b1;
		end else if (p3) begin
			r.done = 1'b1;
		end else begin
			r.err = 1'b1;
		end
		return r;
	endfunction

	// parse state
	phase_t      ph_q, n_ph;
	logic [23:0] cnt_q, n_cnt;
	logic        last_q, n_last;
	logic        bin_q, n_bin;
	logic [15:0] w_q, n_w, h_q, n_h, max_q, n_max, acc_q, n_acc;
	logic        num_q, n_num, com_q, n_com;
	logic [1:0]  comp_q, n_comp;
	logic [15:0] red_q, n_red;
	logic [23:0] green_q, n_green, blue_q, n_blue;
	logic [10:0] col_q, n_col, row_q, n_row;
	logic [11:0] left_q, n_left;
	logic        fin_q, n_fin;
	logic        stp_q, n_stp;
	logic [2:0]  code_q, n_code;
	logic        pix_q, n_pix;
	logic        cont_q, n_cont;
	logic [15:0] nv_q, n_nv;
	// payload
	logic [7:0]  byte_q, n_byte;
	logic [12:0] x_q, n_x, y_q, n_y;
	logic [31:0] word_q, n_word;
	logic [29:0] prod_q, n_prod;
	logic        okind_q, n_okind, olast_q, n_olast;
	logic [31:0] oaddr_q, n_oaddr, oword_q, n_oword;
	logic [2:0]  ocode_q, n_ocode;

	logic        div_busy;
	logic [23:0] div_quo;
	logic [23:0] dividend;

	logic        digit;
	logic [3:0]  dval;
	logic [19:0] acc_next;
	logic        stat;
	logic [2:0]  code;
	logic        num_go;
	scan_t       sc;
	phase_t      np;
	logic [23:0] v24;
	logic        ends;
	logic        was_max;
	logic [12:0] xs, ys;
	logic        inb;
	logic        stat_go;

	assign digit    = byte_q >= CH_ZERO && byte_q <= CH_NINE;
	assign dval     = 4'(byte_q - CH_ZERO);
	assign acc_next = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {16'b0, dval};
	assign dividend = {n_nv, 8'b0} - {8'b0, n_nv};
	assign xs = {1'b0, left_q} + {2'b0, col_q};
	assign ys = {1'b0, cfg.top} + {2'b0, row_q};
	assign inb = xs < cfg.scr_w && ys < cfg.scr_h;
	assign ends = ({5'b0, col_q} + 16'd1 >= w_q) && ({5'b0, row_q} + 16'd1 >= h_q);

	always_comb begin
		n_ph = ph_q; n_cnt = cnt_q; n_last = last_q; n_bin = bin_q;
		n_w = w_q; n_h = h_q; n_max = max_q; n_acc = acc_q;
		n_num = num_q; n_com = com_q; n_comp = comp_q;
		n_red = red_q; n_green = green_q; n_blue = blue_q;
		n_col = col_q; n_row = row_q; n_left = left_q;
		n_fin = fin_q; n_stp = stp_q; n_code = code_q; n_pix = pix_q;
		n_cont = cont_q; n_nv = nv_q;
		n_byte = byte_q; n_x = x_q; n_y = y_q; n_word = word_q; n_prod = prod_q;
		n_okind = okind_q; n_olast = olast_q; n_oaddr = oaddr_q;
		n_oword = oword_q; n_ocode = ocode_q;
		stat = 1'b0; code = STS_OK; num_go = 1'b0; sc = '0; np = ph_q;
		v24 = '0; was_max = 1'b0; stat_go = 1'b0;

		if (cmd.load) begin
			n_byte = in_byte;
			if (in_first) begin
				n_cnt = '0; n_ph = PH_MAGIC; n_bin = 1'b0; n_w = '0; n_h = '0;
				n_max = '0; n_acc = '0; n_num = 1'b0; n_com = 1'b0; n_comp = '0;
				n_red = '0; n_green = '0; n_col = '0; n_row = '0; n_left = '0;
				n_fin = 1'b0; n_stp = 1'b0; n_pix = 1'b0;
			end
		end else if (cmd.eval && !fin_q) begin
			n_cnt  = cnt_q + 24'd1;
			n_last = ({1'b0, cnt_q} + 25'd1) >= {1'b0, cfg.flen};
			case (ph_q)
				PH_MAGIC: begin
					if (!cfg.enable) begin
						stat = 1'b1; code = STS_OK;
					end else if (cfg.flen < 24'(MinFileLength)) begin
						stat = 1'b1; code = STS_SHORT;
					end else if (byte_q != CH_P) begin
						stat = 1'b1; code = STS_MAGIC;
					end else begin
						n_ph = PH_FORMAT;
					end
				end
				PH_FORMAT: begin
					n_bin = byte_q == CH_6;
					n_ph  = PH_WIDTH;
				end
				PH_P6: begin
					case (comp_q)
						2'd0: begin n_red = {8'b0, byte_q}; n_comp = 2'd1; end
						2'd1: begin n_green = {16'b0, byte_q}; n_comp = 2'd2; end
						default: begin
							n_blue = {16'b0, byte_q}; n_comp = 2'd0; n_pix = 1'b1;
						end
					endcase
				end
				PH_DONE: begin
					n_ph = PH_DONE;
				end
				default: begin
					if (num_q && digit) begin
						n_acc = (acc_next > 20'd65535) ? 16'hFFFF : acc_next[15:0];
					end else if (num_q) begin
						n_nv = acc_q; n_num = 1'b0; n_acc = '0; n_cont = 1'b1;
						num_go = 1'b1;
					end else begin
						sc = scan_f(byte_q, com_q, ph_q == PH_P3);
						n_com = sc.com;
						if (sc.start) begin
							n_num = 1'b1; n_acc = {12'b0, dval};
						end
						if (sc.done) n_ph = PH_DONE;
						if (sc.err) begin
							stat = 1'b1; code = STS_BADNUM;
						end
					end
				end
			endcase
			if (stat) begin
				n_stp = 1'b1; n_code = code; n_fin = 1'b1;
			end else if (n_last && n_num) begin
				// end of file closes the open number
				n_nv = n_acc; n_num = 1'b0; n_acc = '0; n_cont = 1'b0; num_go = 1'b1;
			end
		end else if (cmd.num) begin
			v24 = (ph_q == PH_P3 && max_q != 16'(FullScale)) ? div_quo : {8'b0, nv_q};
			was_max = ph_q == PH_MAXVAL;
			case (ph_q)
				PH_WIDTH: begin n_w = nv_q; np = PH_HEIGHT; end
				PH_HEIGHT: begin n_h = nv_q; np = PH_MAXVAL; end
				PH_MAXVAL: begin
					n_max = nv_q;
					if (w_q == '0 || h_q == '0 || nv_q == '0) begin
						stat = 1'b1; code = STS_BADNUM;
					end else if (w_q > 16'(MaxImageWidth) || h_q > 16'(MaxImageHeight)) begin
						stat = 1'b1; code = STS_TOOBIG;
					end else begin
						n_left = ({3'b0, cfg.scr_w} > w_q) ?
							12'(({3'b0, cfg.scr_w} - w_q) >> 1) : 12'd0;
						n_col = '0; n_row = '0; n_comp = '0;
						np = bin_q ? PH_P6 : PH_P3;
					end
				end
				PH_P3: begin
					case (comp_q)
						2'd0: begin n_red = v24[15:0]; n_comp = 2'd1; end
						2'd1: begin n_green = v24; n_comp = 2'd2; end
						default: begin n_blue = v24; n_comp = 2'd0; n_pix = 1'b1; end
					endcase
				end
				default: begin
					np = ph_q;
				end
			endcase
			n_ph = np;
			if (stat) begin
				n_stp = 1'b1; n_code = code; n_fin = 1'b1;
			end else if (cont_q) begin
				if (was_max && np == PH_P6) begin
					if (!is_space(byte_q)) begin
						n_red = {8'b0, byte_q}; n_comp = 2'd1;
					end
				end else if ((np == PH_HEIGHT || np == PH_MAXVAL || np == PH_P3) &&
						!(ph_q == PH_P3 && n_pix && ends)) begin
					sc = scan_f(byte_q, com_q, np == PH_P3);
					n_com = sc.com;
					if (sc.done) n_ph = PH_DONE;
					if (sc.err) begin
						n_stp = 1'b1; n_code = STS_BADNUM; n_fin = 1'b1;
					end
				end
			end
		end else if (cmd.pix) begin
			if (pix_q) begin
				n_pix = 1'b0;
				n_x = xs; n_y = ys;
				n_word = {red_q, 16'b0} | {green_q, 8'b0} | {8'b0, blue_q};
				if ({5'b0, col_q} + 16'd1 >= w_q) begin
					n_col = '0;
					n_row = row_q + 11'd1;
					if ({5'b0, row_q} + 16'd1 >= h_q) n_ph = PH_DONE;
				end else begin
					n_col = col_q + 11'd1;
				end
			end
		end else if (cmd.mul) begin
			n_prod = y_q * cfg.pitch;
		end else if (cmd.sum) begin
			n_okind = 1'b0; n_olast = 1'b0; n_ocode = STS_OK; n_oword = word_q;
			n_oaddr = cfg.base + {2'b0, prod_q} + {17'b0, x_q, 2'b0};
		end else if (cmd.fin) begin
			if (stp_q) begin
				stat_go = 1'b1; n_stp = 1'b0; n_ocode = code_q;
			end else if (!fin_q && last_q) begin
				stat_go = 1'b1; n_fin = 1'b1;
				n_ocode = (ph_q == PH_MAGIC || ph_q == PH_FORMAT || ph_q == PH_WIDTH ||
					ph_q == PH_HEIGHT || ph_q == PH_MAXVAL) ? STS_BADNUM : STS_OK;
			end
			if (stat_go) begin
				n_okind = 1'b1; n_olast = 1'b1; n_oaddr = '0; n_oword = '0;
			end
		end
	end

	always_comb begin
		sts.num_go   = num_go;
		sts.need_div = ph_q == PH_P3 && max_q != 16'(FullScale);
		sts.div_busy = div_busy;
		sts.pix_go   = pix_q && inb;
		sts.stat_go  = stp_q || (!fin_q && last_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_MAGIC; cnt_q <= '0; last_q <= 1'b0; bin_q <= 1'b0;
			w_q <= '0; h_q <= '0; max_q <= '0; acc_q <= '0; num_q <= 1'b0;
			com_q <= 1'b0; comp_q <= '0; red_q <= '0; green_q <= '0; blue_q <= '0;
			col_q <= '0; row_q <= '0; left_q <= '0; fin_q <= 1'b0; stp_q <= 1'b0;
			code_q <= STS_OK; pix_q <= 1'b0; cont_q <= 1'b0; nv_q <= '0;
		end else begin
			ph_q <= n_ph; cnt_q <= n_cnt; last_q <= n_last; bin_q <= n_bin;
			w_q <= n_w; h_q <= n_h; max_q <= n_max; acc_q <= n_acc; num_q <= n_num;
			com_q <= n_com; comp_q <= n_comp; red_q <= n_red; green_q <= n_green;
			blue_q <= n_blue; col_q <= n_col; row_q <= n_row; left_q <= n_left;
			fin_q <= n_fin; stp_q <= n_stp; code_q <= n_code; pix_q <= n_pix;
			cont_q <= n_cont; nv_q <= n_nv;
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= n_byte; x_q <= n_x; y_q <= n_y; word_q <= n_word; prod_q <= n_prod;
		okind_q <= n_okind; olast_q <= n_olast; oaddr_q <= n_oaddr;
		oword_q <= n_oword; ocode_q <= n_ocode;
	end

	ppmb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (max_q),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	assign out_kind = okind_q;
	assign out_addr = oaddr_q;
	assign out_word = oword_q;
	assign out_code = ocode_q;
	assign out_last = olast_q;
endmodule
`default_nettype wire

>>> hw/rtl/ppmb_ctrl.sv
`default_nettype none
module ppmb_ctrl import ppmb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	typedef enum logic [9:0] {
		S_IDLE    = 10'b0000000001,
		S_EVAL    = 10'b0000000010,
		S_DIV     = 10'b0000000100,
		S_NUM     = 10'b0000001000,
		S_PIXCHK  = 10'b0000010000,
		S_MUL     = 10'b0000100000,
		S_SUM     = 10'b0001000000,
		S_PIXOUT  = 10'b0010000000,
		S_FIN     = 10'b0100000000,
		S_STATOUT = 10'b1000000000
	} ctl_state_t;

	ctl_state_t state_q, state_n;

	always_comb begin
		state_n   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.num_go && sts.need_div) begin
					cmd.div_start = 1'b1;
					state_n = S_DIV;
				end else if (sts.num_go) begin
					state_n = S_NUM;
				end else begin
					state_n = S_PIXCHK;
				end
			end
			S_DIV: begin
				if (!sts.div_busy) state_n = S_NUM;
			end
			S_NUM: begin
				cmd.num = 1'b1;
				state_n = S_PIXCHK;
			end
			S_PIXCHK: begin
				cmd.pix = 1'b1;
				state_n = sts.pix_go ? S_MUL : S_FIN;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_n = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_n = S_PIXOUT;
			end
			S_PIXOUT: begin
				out_valid = 1'b1;
				if (out_ready) state_n = S_FIN;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_n = sts.stat_go ? S_STATOUT : S_IDLE;
			end
			S_STATOUT: begin
				out_valid = 1'b1;
				if (out_ready) state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_busy |-> state_q == S_DIV) else $error("divider busy outside DIV");

	a_pixout_from_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PIXOUT && $past(state_q) != S_PIXOUT) |-> $past(state_q) == S_SUM)
		else $error("pixel beat not preceded by address sum");

	a_status_ends_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STATOUT && out_ready) |=> state_q == S_IDLE)
		else $error("status beat did not return to idle");
endmodule
`default_nettype wire

>>> hw/rtl/ppm_stream_to_framebuffer_blitter.sv
`default_nettype none
// PPM decoder and framebuffer blitter. File bytes come in one per s_axis beat
// (tuser marks the first byte of a file); each drawn pixel leaves as one m_axis
// beat carrying a 32-bit framebuffer write, and every file ends with a status
// beat (tuser=1, tlast=1). One byte is in flight at a time: a byte passes the
// accept, evaluate, pixel check and finish states, plus a number step when it
// completes a number, plus multiply, sum and the output handshake when it
// completes a drawn pixel, plus the P3 scaling divide (24-step bit-serial
// divider) when maxval is not 255, plus the status handshake. Configuration
// writes must only happen while the block is idle.
module ppm_stream_to_framebuffer_blitter import ppmb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] file_byte
	input  wire logic        s_axis_tuser,  // [0] first_of_file
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [71:0]      m_axis_tdata,  // [31:0] write_address, [63:32] pixel_word,
	                                        // [66:64] status_code, rest zero
	output logic             m_axis_tuser,  // [0] kind
	output logic             m_axis_tlast,  // last_of_run
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	logic [31:0] o_addr, o_word;
	logic [2:0]  o_code;
	logic        o_kind, o_last;

	// register file, reset to the documented defaults
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= 1'b1;
			cfg_q.scr_w  <= 13'd1024;
			cfg_q.scr_h  <= 13'd768;
			cfg_q.pitch  <= 17'd4096;
			cfg_q.base   <= '0;
			cfg_q.top    <= '0;
			cfg_q.flen   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE: cfg_q.enable <= cfg_data[0];
				REG_SCR_W:  cfg_q.scr_w  <= cfg_data[12:0];
				REG_SCR_H:  cfg_q.scr_h  <= cfg_data[12:0];
				REG_PITCH:  cfg_q.pitch  <= cfg_data[16:0];
				REG_BASE:   cfg_q.base   <= cfg_data;
				REG_TOP:    cfg_q.top    <= cfg_data[11:0];
				REG_LENGTH: cfg_q.flen   <= cfg_data[23:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	ppmb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ppmb_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.sts      (sts),
		.in_byte  (s_axis_tdata),
		.in_first (s_axis_tuser),
		.out_kind (o_kind),
		.out_addr (o_addr),
		.out_word (o_word),
		.out_code (o_code),
		.out_last (o_last)
	);

	assign m_axis_tdata = {5'b0, o_code, o_word, o_addr};
	assign m_axis_tuser = o_kind;
	assign m_axis_tlast = o_last;
endmodule
`default_nettype wire
